### sv/owbm_pkg.sv
// Shared types, constants and helpers for the one-wire bus master.
`default_nettype none

package owbm_pkg;

   // Interval timer width and configuration register width
   localparam int TIMER_BITS = 10;
   localparam int CFG_W      = 10;
   localparam int NUM_CFG    = 8;
   localparam int CFG_IDX_W  = $clog2(NUM_CFG);
   localparam int CSR_ADDR_W = CFG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;
   localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Configuration register indexes
   localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_RESET_RELEASE = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_LOW  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE   = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY  = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVERY = 3'd7;

   localparam logic [CFG_W-1:0] CFG_RESET_VAL [NUM_CFG] = '{
      10'd750, 10'd15, 10'd200, 10'd240, 10'd2, 10'd60, 10'd12, 10'd50
   };

   typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_array_type;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
      logic       line_level;
   } req_beat_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence_fail;
      logic [7:0] read_data;
   } rsp_beat_type;

   // Interval length from a register: zero counts as one, clamp to the timer range
   function automatic logic [TIMER_BITS-1:0] load_interval(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = (v == '0) ? CMP_W'(1) : CMP_W'(v);
      if (w > CMP_W'(TIMER_MAX)) begin
         w = CMP_W'(TIMER_MAX);
      end
      return TIMER_BITS'(w);
   endfunction

endpackage

`default_nettype wire

### sv/owbm_seq.sv
// Bus sequencer: phase state, interval timer, bit shifter and per-tick result logic.
`default_nettype none

module owbm_seq
   import owbm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire req_beat_type  beat,
   input  wire cfg_array_type cfg,
   output rsp_beat_type       result
);

   typedef enum logic [9:0] {
      PH_IDLE      = 10'b0000000001,
      PH_RST_LOW   = 10'b0000000010,
      PH_RST_REL   = 10'b0000000100,
      PH_WAIT_FALL = 10'b0000001000,
      PH_WAIT_RISE = 10'b0000010000,
      PH_W_LOW     = 10'b0000100000,
      PH_W_REL     = 10'b0001000000,
      PH_R_LOW     = 10'b0010000000,
      PH_R_WAIT    = 10'b0100000000,
      PH_R_REC     = 10'b1000000000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [2:0]            bit_ff, bit_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  fail_ff, fail_in;
   logic [7:0]            last_ff, last_in;
   logic                  drive, busy, done;

   // Work out one tick: start a command when idle, then advance the phase
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      fail_in  = fail_ff;
      last_in  = last_ff;
      drive    = 1'b0;
      done     = 1'b0;

      if (phase_in == PH_IDLE && beat.command != CMD_TICK) begin
         bit_in = '0;
         unique case (beat.command)
            CMD_RESET: begin
               fail_in  = 1'b0;
               phase_in = PH_RST_LOW;
               timer_in = load_interval(cfg[CFG_RESET_LOW]);
            end
            CMD_WRITE: begin
               shift_in = beat.data_byte;
               phase_in = PH_W_LOW;
               timer_in = load_interval(beat.data_byte[0] ? cfg[CFG_SHORT_PULSE]
                                                          : cfg[CFG_LONG_PULSE]);
            end
            CMD_READ: begin
               shift_in = '0;
               phase_in = PH_R_LOW;
               timer_in = load_interval(cfg[CFG_SHORT_PULSE]);
            end
            CMD_TICK: begin
            end
         endcase
      end

      busy = (phase_in != PH_IDLE);

      unique case (phase_in)
         PH_IDLE: begin
         end
         PH_RST_LOW: begin
            drive = 1'b1;
            if (timer_in <= TIMER_BITS'(1)) begin
               phase_in = PH_RST_REL;
               timer_in = load_interval(cfg[CFG_RESET_RELEASE]);
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         PH_RST_REL: begin
            if (timer_in <= TIMER_BITS'(1)) begin
               phase_in = PH_WAIT_FALL;
               timer_in = '0;
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         PH_WAIT_FALL: begin
            if (beat.line_level) begin
               timer_in = timer_in + TIMER_BITS'(1);
               if (timer_in >= load_interval(cfg[CFG_PRESENCE_WAIT])) begin
                  fail_in = 1'b1;
                  done    = 1'b1;
               end
            end else begin
               // the first low sample already counts towards the rise wait
               phase_in = PH_WAIT_RISE;
               timer_in = TIMER_BITS'(1);
               if (timer_in >= load_interval(cfg[CFG_PRESENCE_LOW])) begin
                  fail_in = 1'b1;
                  done    = 1'b1;
               end
            end
         end
         PH_WAIT_RISE: begin
            if (beat.line_level) begin
               done = 1'b1;
            end else begin
               timer_in = timer_in + TIMER_BITS'(1);
               if (timer_in >= load_interval(cfg[CFG_PRESENCE_LOW])) begin
                  fail_in = 1'b1;
                  done    = 1'b1;
               end
            end
         end
         PH_W_LOW: begin
            drive = 1'b1;
            if (timer_in <= TIMER_BITS'(1)) begin
               phase_in = PH_W_REL;
               timer_in = load_interval(shift_in[0] ? cfg[CFG_LONG_PULSE]
                                                    : cfg[CFG_SHORT_PULSE]);
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         PH_W_REL: begin
            if (timer_in <= TIMER_BITS'(1)) begin
               timer_in = '0;
               if (bit_in == 3'd7) begin
                  done = 1'b1;
               end else begin
                  bit_in   = bit_in + 3'd1;
                  shift_in = {1'b0, shift_in[7:1]};
                  phase_in = PH_W_LOW;
                  timer_in = load_interval(shift_in[0] ? cfg[CFG_SHORT_PULSE]
                                                       : cfg[CFG_LONG_PULSE]);
               end
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         PH_R_LOW: begin
            drive = 1'b1;
            if (timer_in <= TIMER_BITS'(1)) begin
               phase_in = PH_R_WAIT;
               timer_in = load_interval(cfg[CFG_SAMPLE_DELAY]);
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         PH_R_WAIT: begin
            // sample on the last tick of the delay, shift in from the top
            if (timer_in <= TIMER_BITS'(1)) begin
               shift_in = {beat.line_level, shift_in[7:1]};
               phase_in = PH_R_REC;
               timer_in = load_interval(cfg[CFG_READ_RECOVERY]);
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         PH_R_REC: begin
            if (timer_in <= TIMER_BITS'(1)) begin
               timer_in = '0;
               if (bit_in == 3'd7) begin
                  last_in = shift_in;
                  done    = 1'b1;
               end else begin
                  bit_in   = bit_in + 3'd1;
                  phase_in = PH_R_LOW;
                  timer_in = load_interval(cfg[CFG_SHORT_PULSE]);
               end
            end else begin
               timer_in = timer_in - TIMER_BITS'(1);
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (done) begin
         phase_in = PH_IDLE;
         timer_in = '0;
      end
   end

   // Drive the result of this tick
   always_comb begin
      result.drive_low     = drive;
      result.busy_res      = busy;
      result.done_res      = done;
      result.presence_fail = fail_in;
      result.read_data     = last_in;
   end

   // Advance the state once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         fail_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         fail_ff  <= fail_in;
         last_ff  <= last_in;
      end
   end

`ifndef SYNTH
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done_res |-> result.busy_res)
      else $error("done without busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && result.done_res |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after completion");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      step_en && result.drive_low |-> result.busy_res)
      else $error("bus pulled low while idle");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> timer_ff == '0)
      else $error("interval timer running while idle");
`endif

endmodule

`default_nettype wire

### sv/one_wire_bus_master_core.sv
// Top level of the one-wire bus master: register port, input stage and result stage.
//
// Usage: every req_ beat is one microsecond tick carrying a command (tick only,
// reset and detect, write byte, read byte), the byte to write and the sampled
// bus level. Each accepted beat yields exactly one rsp_ beat with drive_low
// (open-drain pull), busy, a one-tick done flag, the held presence result and
// the held byte of the last completed read.
// The accept edge loads the input register; once the result stage is free or
// being drained, the sequencer steps into the result register, which drives
// rsp_valid. One beat every cycle while rsp_stall is low.
// A command is taken only while the sequencer is idle; commands arriving while
// an operation runs are ignored.
// Timing registers sit on the csr_ port at byte address 4*index; write them only
// while the block is idle. A zero value counts as one tick.
// Reset (synchronous) empties both stages, idles the sequencer and loads the
// default timings. When rsp_stall is high the result stage holds, the input
// stage fills, and req_stall rises only once both are occupied.
`default_nettype none

module one_wire_bus_master_core
   import owbm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_beat_type          req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_beat_type               rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [CFG_W-1:0] cfg_ff [NUM_CFG];
   cfg_array_type    cfg_vec;
   logic             cfg_wr;
   logic [CFG_IDX_W-1:0] cfg_idx;

   logic         in_valid_ff, in_valid_in;
   req_beat_type in_data_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_data_ff;
   rsp_beat_type step_result;
   logic         req_fire, step_fire, rsp_fire;

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = CSR_DATA_W'(cfg_ff[cfg_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG; i++) begin
            cfg_ff[i] <= CFG_RESET_VAL[i];
         end
      end else if (cfg_wr) begin
         cfg_ff[cfg_idx] <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CFG; i++) begin
         cfg_vec[i] = cfg_ff[i];
      end
   end

   // Handshake: step when the result stage is free or being drained
   assign step_fire = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_fire;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold the input beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
   end

   owbm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_fire),
      .beat    (in_data_ff),
      .cfg     (cfg_vec),
      .result  (step_result)
   );

   // Hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
